// ----- src/esc_strip_pkg.sv -----
// shared types, state codes and the single-pass parse function of the escape stripper
`default_nettype none

package esc_strip_pkg;

   // parser state codes
   localparam logic [2:0] ST_TEXT    = 3'd0;
   localparam logic [2:0] ST_ESC     = 3'd1;
   localparam logic [2:0] ST_CSI     = 3'd2;
   localparam logic [2:0] ST_OSC     = 3'd3;
   localparam logic [2:0] ST_OSC_ESC = 3'd4;
   localparam logic [2:0] ST_STR     = 3'd5;
   localparam logic [2:0] ST_STR_ESC = 3'd6;
   localparam logic [2:0] ST_ESC_INT = 3'd7;

   // outcome of one parse pass
   localparam logic [1:0] ACT_DROP  = 2'd0;
   localparam logic [1:0] ACT_KEEP  = 2'd1;
   localparam logic [1:0] ACT_AGAIN = 2'd2;

   // byte constants
   localparam logic [7:0] CH_BEL   = 8'h07;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_CAN   = 8'h18;
   localparam logic [7:0] CH_SUB   = 8'h1a;
   localparam logic [7:0] CH_ESC   = 8'h1b;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_INT_HI = 8'h2f;
   localparam logic [7:0] CH_FIN_LO = 8'h30;
   localparam logic [7:0] CH_CSI_LO = 8'h40;
   localparam logic [7:0] CH_DCS   = 8'h50;
   localparam logic [7:0] CH_CSI   = 8'h5b;
   localparam logic [7:0] CH_BSL   = 8'h5c;
   localparam logic [7:0] CH_OSC   = 8'h5d;
   localparam logic [7:0] CH_PM    = 8'h5e;
   localparam logic [7:0] CH_APC   = 8'h5f;
   localparam logic [7:0] CH_FIN_HI = 8'h7e;
   localparam logic [7:0] CH_DEL   = 8'h7f;

   typedef struct packed {
      logic [2:0] next_state;
      logic [1:0] act;
   } pass_type;

   function automatic logic is_cancel(input logic [7:0] b);
      return (b == CH_LF) || (b == CH_CAN) || (b == CH_SUB);
   endfunction

   function automatic logic is_plain_text(input logic [7:0] b);
      return (b == CH_TAB) || (b == CH_LF) || ((b >= CH_SPACE) && (b != CH_DEL));
   endfunction

   // one pass of the parser over one byte
   function automatic pass_type parse_pass(input logic [2:0] st, input logic [7:0] b);
      pass_type r;
      r.next_state = st;
      r.act        = ACT_DROP;
      unique case (st)
         ST_TEXT: begin
            if (b == CH_ESC) begin
               r.next_state = ST_ESC;
            end else if (is_plain_text(b)) begin
               r.act = ACT_KEEP;
            end
         end
         ST_ESC: begin
            if (b == CH_CSI) begin
               r.next_state = ST_CSI;
            end else if (b == CH_OSC) begin
               r.next_state = ST_OSC;
            end else if ((b == CH_DCS) || (b == CH_PM) || (b == CH_APC)) begin
               r.next_state = ST_STR;
            end else if ((b >= CH_SPACE) && (b <= CH_INT_HI)) begin
               r.next_state = ST_ESC_INT;
            end else if ((b >= CH_FIN_LO) && (b <= CH_FIN_HI)) begin
               r.next_state = ST_TEXT;
            end else begin
               r.next_state = ST_TEXT;
               r.act        = ACT_AGAIN;
            end
         end
         ST_CSI: begin
            if (is_cancel(b)) begin
               r.next_state = ST_TEXT;
               r.act        = ACT_AGAIN;
            end else if ((b >= CH_CSI_LO) && (b <= CH_FIN_HI)) begin
               r.next_state = ST_TEXT;
            end
         end
         ST_OSC: begin
            if (is_cancel(b)) begin
               r.next_state = ST_TEXT;
               r.act        = ACT_AGAIN;
            end else if (b == CH_BEL) begin
               r.next_state = ST_TEXT;
            end else if (b == CH_ESC) begin
               r.next_state = ST_OSC_ESC;
            end
         end
         ST_OSC_ESC: begin
            if (b == CH_BSL) begin
               r.next_state = ST_TEXT;
            end else begin
               r.next_state = is_cancel(b) ? ST_TEXT : ST_OSC;
               r.act        = ACT_AGAIN;
            end
         end
         ST_STR: begin
            if (is_cancel(b)) begin
               r.next_state = ST_TEXT;
               r.act        = ACT_AGAIN;
            end else if (b == CH_ESC) begin
               r.next_state = ST_STR_ESC;
            end
         end
         ST_STR_ESC: begin
            if (b == CH_BSL) begin
               r.next_state = ST_TEXT;
            end else begin
               r.next_state = is_cancel(b) ? ST_TEXT : ST_STR;
               r.act        = ACT_AGAIN;
            end
         end
         ST_ESC_INT: begin
            if (is_cancel(b)) begin
               r.next_state = ST_TEXT;
               r.act        = ACT_AGAIN;
            end else if ((b >= CH_FIN_LO) && (b <= CH_FIN_HI)) begin
               r.next_state = ST_TEXT;
            end
         end
         default: begin
            r.next_state = ST_TEXT;
         end
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- src/esc_strip_parser.sv -----
// parser state register with the two-pass byte classification
`default_nettype none

module esc_strip_parser (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic [7:0] byte_in,
   output logic            keep
);
   import esc_strip_pkg::*;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   pass_type   pass_a;
   pass_type   pass_b;
   pass_type   final_pass;

   // first pass, then a second one from the state the first left when asked to reparse
   always_comb begin
      pass_a     = parse_pass(state_ff, byte_in);
      pass_b     = parse_pass(pass_a.next_state, byte_in);
      final_pass = (pass_a.act == ACT_AGAIN) ? pass_b : pass_a;
      keep       = (final_pass.act == ACT_KEEP);
      state_in   = step ? final_pass.next_state : state_ff;
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_TEXT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/escape_sequence_stripper.sv -----
// a req word goes from the input register to the result register, which drives rsp
// throughput: one word per cycle while rsp is not stalled
// an input register and a result register part the two sides, so a new word is taken
// into an empty input register while a finished result waits for rsp_stall to drop
// reset (synchronous, active high) empties both registers, returns the parser to
// text state and clears line mode
`default_nettype none

module escape_sequence_stripper (
   input  wire logic       clock,
   input  wire logic       reset,
   // input channel
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_chunk_end,
   // result channel
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_keep,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_out_last,
   // configuration write
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic       csr_line_mode
);
   import esc_strip_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       out_valid_ff, out_valid_in;
   logic       out_keep_ff;
   logic [7:0] out_byte_ff;
   logic       out_last_ff;
   logic       line_mode_ff, line_mode_in;
   logic       accept;
   logic       advance;
   logic       parse_keep;
   logic [7:0] mapped_byte;

   // handshake control
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign in_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_stall ? out_valid_ff : 1'b0);
   assign line_mode_in = csr_valid ? csr_line_mode : line_mode_ff;

   esc_strip_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .byte_in (in_byte_ff),
      .keep    (parse_keep)
   );

   // line mode turns kept tab and newline into a space
   always_comb begin
      mapped_byte = in_byte_ff;
      if (line_mode_ff && ((in_byte_ff == CH_TAB) || (in_byte_ff == CH_LF))) begin
         mapped_byte = CH_SPACE;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         line_mode_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         line_mode_ff <= line_mode_in;
      end
   end

   // input word register
   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_in_byte;
         in_last_ff <= req_chunk_end;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (advance) begin
         out_keep_ff <= parse_keep;
         out_byte_ff <= parse_keep ? mapped_byte : 8'h00;
         out_last_ff <= in_last_ff;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_keep     = out_keep_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_out_last = out_last_ff;

endmodule

`default_nettype wire

// ----- src/esc_strip_checker.sv -----
// port-level checks for the escape stripper and their bind
`default_nettype none

module esc_strip_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic       rsp_keep,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_out_last
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_keep) && $stable(rsp_out_last))
      else $error("stalled result word changed");

   // dropped bytes come out as zero
   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_keep |-> rsp_out_byte == 8'h00)
      else $error("dropped word carries a nonzero byte");

   // ESC and DEL are never passed on
   a_no_esc_del: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_keep |-> rsp_out_byte != 8'h1b && rsp_out_byte != 8'h7f)
      else $error("ESC or DEL passed as text");

   // the only kept C0 controls are tab and newline
   a_kept_ctrl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_keep && rsp_out_byte < 8'h20
         |-> rsp_out_byte == 8'h09 || rsp_out_byte == 8'h0a)
      else $error("C0 control other than tab or newline passed");

   // out of reset both sides are empty
   a_reset_empty: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

endmodule

bind escape_sequence_stripper esc_strip_checker u_esc_strip_checker (
   .clock        (clock),
   .reset        (reset),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_keep     (rsp_keep),
   .rsp_out_byte (rsp_out_byte),
   .rsp_out_last (rsp_out_last)
);

`default_nettype wire
